// ----- src/u8f_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8f_pkg
// Shared types, constants and the lead byte decode for the UTF-8 byte filter.
// ----------------------------------------------------------------------------
package u8f_pkg;

  // one result entry as it sits in the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
  } res_t;

  // most results one input byte can cause
  localparam int unsigned MaxRes   = 4;
  // entries of the output queue
  localparam int unsigned QueueLen = 8;

  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContValue = 8'h80;

  // sequence length announced by a byte, zero for a byte that cannot start one
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    priority if (b <= AsciiMax) begin
      len = 3'd1;
    end else if (b >= Lead2Min && b <= Lead2Max) begin
      len = 3'd2;
    end else if (b >= Lead3Min && b <= Lead3Max) begin
      len = 3'd3;
    end else if (b >= Lead4Min && b <= Lead4Max) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- src/utf8_invalid_byte_filter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_invalid_byte_filter_top
// Streaming UTF-8 sanitizer: passes ASCII and complete multi-byte sequences,
// drops broken sequences, stray continuations and invalid lead bytes.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle unless stalled. Each byte is judged in the
// cycle it is transferred, against the pending sequence held in registers,
// and the up to four results it causes are written into an eight-entry
// output queue in the same edge, behind earlier entries. Results leave the
// queue one per cycle while out_ready is high; since every byte is emitted
// at most once, a stream of valid text sustains one byte per cycle. The input
// stalls only when the queue would have fewer than four free entries after
// the current output transfer. A string's final byte always ends in a result
// with out_string_done set, a bare marker (out_byte_valid low) if nothing else.
module utf8_invalid_byte_filter_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_done
);

  localparam int unsigned CntW = $clog2(u8f_pkg::QueueLen + 1);

  // pending sequence
  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] seq_len_r, seq_len_nxt;
  logic       held_we;
  logic [1:0] held_idx;

  // output queue, entry 0 is the head
  u8f_pkg::res_t q_r [u8f_pkg::QueueLen];
  u8f_pkg::res_t q_nxt [u8f_pkg::QueueLen];
  logic [CntW-1:0] cnt_r, cnt_nxt;

  u8f_pkg::res_t res [u8f_pkg::MaxRes];
  logic [2:0]      n_res;
  logic            pop, push;
  logic [CntW-1:0] cnt_pop;
  logic            is_cont;
  logic [2:0]      len;

  // handshakes
  assign out_valid       = (cnt_r != '0);
  assign pop             = out_valid && out_ready;
  assign cnt_pop         = cnt_r - {{(CntW-1){1'b0}}, pop};
  assign in_ready        = (cnt_pop <= CntW'(u8f_pkg::QueueLen - u8f_pkg::MaxRes));
  assign push            = in_valid && in_ready;
  assign out_byte        = q_r[0].data;
  assign out_byte_valid  = q_r[0].valid;
  assign out_string_done = q_r[0].done;

  // judge the incoming byte against the pending sequence
  always_comb begin
    is_cont      = ((in_byte & u8f_pkg::ContMask) == u8f_pkg::ContValue);
    len          = u8f_pkg::lead_length(in_byte);
    held_cnt_nxt = held_cnt_r;
    seq_len_nxt  = seq_len_r;
    held_we      = 1'b0;
    held_idx     = held_cnt_r;
    n_res        = 3'd0;
    for (int i = 0; i < int'(u8f_pkg::MaxRes); i++) begin
      res[i] = '{data: in_byte, valid: 1'b1, done: 1'b0};
    end

    if (seq_len_r != 3'd0 && is_cont) begin
      if (({1'b0, held_cnt_r} + 3'd1) >= seq_len_r) begin
        // sequence complete: held bytes, then this one
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_cnt_r) begin
            res[i].data = held_r[i];
          end
        end
        n_res        = {1'b0, held_cnt_r} + 3'd1;
        held_cnt_nxt = 2'd0;
        seq_len_nxt  = 3'd0;
      end else begin
        held_we      = 1'b1;
        held_cnt_nxt = held_cnt_r + 2'd1;
      end
    end else begin
      // new lead, ascii, or dropped byte
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
      if (len == 3'd1) begin
        n_res = 3'd1;
      end else if (len >= 3'd2) begin
        held_we      = 1'b1;
        held_idx     = 2'd0;
        held_cnt_nxt = 2'd1;
        seq_len_nxt  = len;
      end
    end

    // end of string: drop partial, mark the last result
    if (in_end_of_string) begin
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
      if (n_res == 3'd0) begin
        res[0] = '{data: 8'h00, valid: 1'b0, done: 1'b1};
        n_res  = 3'd1;
      end else begin
        res[n_res[1:0] - 2'd1].done = 1'b1;
      end
    end
  end

  // queue update: shift on output transfer, append results after survivors
  always_comb begin
    logic [CntW-1:0] off;
    off = '0;
    for (int j = 0; j < int'(u8f_pkg::QueueLen); j++) begin
      if (pop && j < int'(u8f_pkg::QueueLen) - 1) begin
        q_nxt[j] = q_r[j+1];
      end else begin
        q_nxt[j] = q_r[j];
      end
      off = CntW'(j) - cnt_pop;
      if (push && CntW'(j) >= cnt_pop && off < CntW'(n_res)) begin
        q_nxt[j] = res[off[1:0]];
      end
    end
    cnt_nxt = cnt_pop + (push ? CntW'(n_res) : '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      held_cnt_r <= 2'd0;
      seq_len_r  <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        held_cnt_r <= held_cnt_nxt;
        seq_len_r  <= seq_len_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (push && held_we) begin
      held_r[held_idx] <= in_byte;
    end
  end

endmodule
`default_nettype wire

// ----- src/u8f_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8f_checker
// Port-level checks for the UTF-8 byte filter, bound to the top level.
// ----------------------------------------------------------------------------
module u8f_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_string_done
);

  // nothing left in the queue after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a waiting input transfer stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before transfer");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  // a bare marker is always a zero byte that ends a string
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_string_done && out_byte == 8'h00)
    else $error("bare result that is not an end marker");

  // invalid leads never reach the output
  a_no_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |->
      out_byte != 8'hC0 && out_byte != 8'hC1 && out_byte < 8'hF5)
    else $error("invalid byte emitted");

endmodule

bind utf8_invalid_byte_filter_top u8f_checker u_u8f_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_string_done (out_string_done)
);
`default_nettype wire
